@@ rtl/core/qrp_pkg.sv @@
`default_nettype none

package qrp_pkg;

  localparam int COORD_W    = 24;
  localparam int ANGLE_W    = 16;
  localparam int ROT_STAGES = 16;
  localparam int TABLE_LEN  = 24;
  localparam int NSTG       = (ROT_STAGES < TABLE_LEN) ? ROT_STAGES : TABLE_LEN;
  localparam int GUARD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int KINV_W     = 31;
  localparam int PROD_W     = DIFF_W + KINV_W;
  // |x|,|y| stay below |offset| * sqrt(2) * 2^GUARD_W through every stage
  localparam int WORK_W     = COORD_W + GUARD_W + 4;
  localparam int SUM_W      = WORK_W - GUARD_W + 1;
  localparam int TURN_W     = 32;
  localparam int Z_W        = TURN_W + 1;
  localparam int PRE_SHIFT  = 30 - GUARD_W;
  // offset, product, prescale, NSTG micro-rotations, output round
  localparam int DEPTH      = NSTG + 4;
  localparam int NUM_LANES  = 4;

  // 1/K in Q0.30
  localparam logic signed [KINV_W-1:0] KINV_Q30 = 31'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [TURN_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic            flip;
    logic [NSTG-1:0] ccw;
  } lane_ctl_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic fits;
    fits = (&v[SUM_W-1:COORD_W-1]) | ~(|v[SUM_W-1:COORD_W-1]);
    if (fits) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/qrp_in_if.sv @@
`default_nettype none

interface qrp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrp_pkg::COORD_W-1:0]   p0_x;
  logic signed [qrp_pkg::COORD_W-1:0]   p0_y;
  logic signed [qrp_pkg::COORD_W-1:0]   p1_x;
  logic signed [qrp_pkg::COORD_W-1:0]   p1_y;
  logic signed [qrp_pkg::COORD_W-1:0]   p2_x;
  logic signed [qrp_pkg::COORD_W-1:0]   p2_y;
  logic signed [qrp_pkg::COORD_W-1:0]   p3_x;
  logic signed [qrp_pkg::COORD_W-1:0]   p3_y;
  logic signed [qrp_pkg::COORD_W-1:0]   pivot_x;
  logic signed [qrp_pkg::COORD_W-1:0]   pivot_y;
  logic signed [qrp_pkg::ANGLE_W-1:0]   angle;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
           pivot_x, pivot_y, angle,
    input  ready
  );

  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
           pivot_x, pivot_y, angle,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/qrp_out_if.sv @@
`default_nettype none

interface qrp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrp_pkg::COORD_W-1:0]   r0_x;
  logic signed [qrp_pkg::COORD_W-1:0]   r0_y;
  logic signed [qrp_pkg::COORD_W-1:0]   r1_x;
  logic signed [qrp_pkg::COORD_W-1:0]   r1_y;
  logic signed [qrp_pkg::COORD_W-1:0]   r2_x;
  logic signed [qrp_pkg::COORD_W-1:0]   r2_y;
  logic signed [qrp_pkg::COORD_W-1:0]   r3_x;
  logic signed [qrp_pkg::COORD_W-1:0]   r3_y;

  modport source (
    output valid, r0_x, r0_y, r1_x, r1_y, r2_x, r2_y, r3_x, r3_y,
    input  ready
  );

  modport sink (
    input  valid, r0_x, r0_y, r1_x, r1_y, r2_x, r2_y, r3_x, r3_y,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/qrp_ctrl.sv @@
`default_nettype none

// Shared angle path: quadrant fold, residual angle per stage, pivot and valid delay.
module qrp_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [qrp_pkg::ANGLE_W-1:0]  angle_i,
  input  qrp_pkg::point_t                     pivot_i,
  output qrp_pkg::lane_ctl_t                  ctl_o,
  output qrp_pkg::point_t                     pivot_o,
  output logic                                valid_o
);

  logic [qrp_pkg::TURN_W-1:0]       turn;
  logic                             flip_d;
  logic signed [qrp_pkg::Z_W-1:0]   z_d;

  logic [1:0]                       flip_q;
  logic signed [qrp_pkg::Z_W-1:0]   z_q [qrp_pkg::NSTG+2];
  qrp_pkg::point_t                  pivot_q [qrp_pkg::DEPTH-1];
  logic [qrp_pkg::DEPTH-1:0]        valid_q;

  assign turn   = {angle_i, {(qrp_pkg::TURN_W-qrp_pkg::ANGLE_W){1'b0}}};
  // second and third quadrants: negate the vector and fold by a half turn
  assign flip_d = turn[qrp_pkg::TURN_W-1] ^ turn[qrp_pkg::TURN_W-2];
  assign z_d    = qrp_pkg::Z_W'($signed({turn[qrp_pkg::TURN_W-1] ^ flip_d,
                                         turn[qrp_pkg::TURN_W-2:0]}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[qrp_pkg::DEPTH-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flip_q  <= {flip_q[0], flip_d};
      z_q[0]  <= z_d;
      z_q[1]  <= z_q[0];
      z_q[2]  <= z_q[1];
      pivot_q[0] <= pivot_i;
      for (int k = 1; k < qrp_pkg::DEPTH-1; k++) begin
        pivot_q[k] <= pivot_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < qrp_pkg::NSTG-1; i++) begin : g_zstage
    localparam logic signed [qrp_pkg::Z_W-1:0] ZT =
      qrp_pkg::Z_W'(qrp_pkg::ATAN_TURNS[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[3+i] <= z_q[2+i][qrp_pkg::Z_W-1] ? (z_q[2+i] + ZT) : (z_q[2+i] - ZT);
      end
    end
  end

  for (genvar i = 0; i < qrp_pkg::NSTG; i++) begin : g_dir
    assign ctl_o.ccw[i] = ~z_q[2+i][qrp_pkg::Z_W-1];
  end

  assign ctl_o.flip = flip_q[1];
  assign pivot_o    = pivot_q[qrp_pkg::DEPTH-2];
  assign valid_o    = valid_q[qrp_pkg::DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/core/qrp_lane.sv @@
`default_nettype none

// One corner: offset, gain prescale, micro-rotation stages, round, re-add pivot.
module qrp_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  qrp_pkg::point_t     p_i,
  input  qrp_pkg::point_t     pivot_i,
  input  qrp_pkg::lane_ctl_t  ctl_i,
  input  qrp_pkg::point_t     pivot_dly_i,
  output qrp_pkg::point_t     r_o
);

  localparam logic signed [qrp_pkg::PROD_W-1:0] PRE_HALF =
    qrp_pkg::PROD_W'(1) << (qrp_pkg::PRE_SHIFT - 1);
  localparam logic signed [qrp_pkg::WORK_W-1:0] OUT_HALF =
    qrp_pkg::WORK_W'(1) << (qrp_pkg::GUARD_W - 1);

  logic signed [qrp_pkg::DIFF_W-1:0]  dx_q, dy_q;
  logic signed [qrp_pkg::PROD_W-1:0]  px_q, py_q;
  logic signed [qrp_pkg::PROD_W-1:0]  pxr, pyr;
  logic signed [qrp_pkg::WORK_W-1:0]  xr, yr;
  logic signed [qrp_pkg::WORK_W-1:0]  x_q [qrp_pkg::NSTG+1];
  logic signed [qrp_pkg::WORK_W-1:0]  y_q [qrp_pkg::NSTG+1];
  logic signed [qrp_pkg::WORK_W-1:0]  xe, ye;
  logic signed [qrp_pkg::SUM_W-1:0]   xs, ys;
  qrp_pkg::point_t                    r_q;

  assign pxr = px_q + PRE_HALF;
  assign pyr = py_q + PRE_HALF;
  assign xr  = qrp_pkg::WORK_W'(pxr >>> qrp_pkg::PRE_SHIFT);
  assign yr  = qrp_pkg::WORK_W'(pyr >>> qrp_pkg::PRE_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= qrp_pkg::DIFF_W'($signed(p_i.x)) - qrp_pkg::DIFF_W'($signed(pivot_i.x));
      dy_q   <= qrp_pkg::DIFF_W'($signed(p_i.y)) - qrp_pkg::DIFF_W'($signed(pivot_i.y));
      px_q   <= dx_q * qrp_pkg::KINV_Q30;
      py_q   <= dy_q * qrp_pkg::KINV_Q30;
      x_q[0] <= ctl_i.flip ? -xr : xr;
      y_q[0] <= ctl_i.flip ? -yr : yr;
    end
  end

  for (genvar i = 0; i < qrp_pkg::NSTG; i++) begin : g_stage
    logic signed [qrp_pkg::WORK_W-1:0] sx, sy;
    assign sx = x_q[i] >>> i;
    assign sy = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ctl_i.ccw[i]) begin
          x_q[i+1] <= x_q[i] - sy;
          y_q[i+1] <= y_q[i] + sx;
        end else begin
          x_q[i+1] <= x_q[i] + sy;
          y_q[i+1] <= y_q[i] - sx;
        end
      end
    end
  end

  assign xe = x_q[qrp_pkg::NSTG] + OUT_HALF;
  assign ye = y_q[qrp_pkg::NSTG] + OUT_HALF;
  assign xs = qrp_pkg::SUM_W'(xe >>> qrp_pkg::GUARD_W)
            + qrp_pkg::SUM_W'($signed(pivot_dly_i.x));
  assign ys = qrp_pkg::SUM_W'(ye >>> qrp_pkg::GUARD_W)
            + qrp_pkg::SUM_W'($signed(pivot_dly_i.y));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q.x <= qrp_pkg::sat_coord(xs);
      r_q.y <= qrp_pkg::sat_coord(ys);
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

@@ rtl/core/qrp_merge.sv @@
`default_nettype none

// Gathers the four lane results into one beat; two-entry skid buffer at the output.
module qrp_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        push_i,
  input  qrp_pkg::point_t [qrp_pkg::NUM_LANES-1:0]    res_i,
  output logic                                        ready_o,
  qrp_out_if.source                                   out_o
);

  qrp_pkg::point_t [qrp_pkg::NUM_LANES-1:0] buf_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = out_o.valid & out_o.ready;
  assign ready_o = (cnt_q != 2'd2);

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop;
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= res_i;
    end
  end

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.r0_x  = buf_q[rd_q][0].x;
  assign out_o.r0_y  = buf_q[rd_q][0].y;
  assign out_o.r1_x  = buf_q[rd_q][1].x;
  assign out_o.r1_y  = buf_q[rd_q][1].y;
  assign out_o.r2_x  = buf_q[rd_q][2].x;
  assign out_o.r2_y  = buf_q[rd_q][2].y;
  assign out_o.r3_x  = buf_q[rd_q][3].x;
  assign out_o.r3_y  = buf_q[rd_q][3].y;

endmodule

`default_nettype wire

@@ rtl/core/quad_rotate_about_pivot.sv @@
// Rotates the four corners of a quadrilateral about a pivot point.
// in_i  : one beat carries corners p0..p3, the pivot and a binary angle
//         (one turn spans the full angle range), coordinates Q15.8.
// out_o : one beat carries the four rotated corners r0..r3, rounded to
//         nearest and saturated to the coordinate range.
// Four lanes, one per corner, each a 20-stage pipeline: offset, 25x31
// gain prescale multiply, quadrant fold, 16 micro-rotation stages and a
// round/pivot/saturate stage. A shared control pipe carries the residual
// angle, the pivot and the valid bits alongside.
// Throughput: one quad per cycle while the output buffer has room. out_o.valid
// rises once the quad has passed the lane stages and been written into
// the two-entry output buffer.
// in_i.ready depends only on the buffer fill, never on out_o.ready; when
// the receiver stalls the buffer fills and the whole pipeline then holds.
// Reset empties the pipeline and the output buffer; no state survives
// between items.
`default_nettype none

module quad_rotate_about_pivot (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrp_in_if.sink     in_i,
  qrp_out_if.source  out_o
);

  logic                                     en;
  logic                                     valid_last;
  qrp_pkg::lane_ctl_t                       ctl;
  qrp_pkg::point_t                          pivot;
  qrp_pkg::point_t                          pivot_dly;
  qrp_pkg::point_t [qrp_pkg::NUM_LANES-1:0] pts;
  qrp_pkg::point_t [qrp_pkg::NUM_LANES-1:0] res;

  assign in_i.ready = en;

  assign pivot.x  = in_i.pivot_x;
  assign pivot.y  = in_i.pivot_y;
  assign pts[0].x = in_i.p0_x;
  assign pts[0].y = in_i.p0_y;
  assign pts[1].x = in_i.p1_x;
  assign pts[1].y = in_i.p1_y;
  assign pts[2].x = in_i.p2_x;
  assign pts[2].y = in_i.p2_y;
  assign pts[3].x = in_i.p3_x;
  assign pts[3].y = in_i.p3_y;

  qrp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .angle_i (in_i.angle),
    .pivot_i (pivot),
    .ctl_o   (ctl),
    .pivot_o (pivot_dly),
    .valid_o (valid_last)
  );

  for (genvar l = 0; l < qrp_pkg::NUM_LANES; l++) begin : g_lane
    qrp_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (en),
      .p_i         (pts[l]),
      .pivot_i     (pivot),
      .ctl_i       (ctl),
      .pivot_dly_i (pivot_dly),
      .r_o         (res[l])
    );
  end

  qrp_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en & valid_last),
    .res_i   (res),
    .ready_o (en),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

@@ tb/quad_rotate_scoreboard.sv @@
`timescale 1ns / 100ps

module quad_rotate_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  qrp_in_if    in_mon,
  qrp_out_if   out_mon,
  output int   mismatch_count_o,
  output int   pending_o
);

  localparam int COORD_W = qrp_pkg::COORD_W;
  localparam int GUARD   = 16;
  localparam int STAGES  = 16;
  localparam longint KINV     = 64'sd652032874;
  localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
  localparam longint COORD_LO = -COORD_HI - 64'sd1;

  // atan(2^-i) in 2^-32 turn units
  localparam longint ATAN_TURN [STAGES] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331,  21354465,  10679838,  5340245,
    2670163,   1335087,   667544,    333772,
    166886,    83443,     41722,     20861
  };

  // index 2k is corner k x, 2k+1 its y
  typedef logic [7:0][COORD_W-1:0] coord8_t;

  coord8_t in_corners;
  coord8_t out_corners;
  coord8_t want;
  coord8_t expected_quads [$];
  int      mismatches;

  assign in_corners = {in_mon.p3_y, in_mon.p3_x, in_mon.p2_y, in_mon.p2_x,
                       in_mon.p1_y, in_mon.p1_x, in_mon.p0_y, in_mon.p0_x};
  assign out_corners = {out_mon.r3_y, out_mon.r3_x, out_mon.r2_y, out_mon.r2_x,
                        out_mon.r1_y, out_mon.r1_x, out_mon.r0_y, out_mon.r0_x};

  function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
    longint c;
    c = v;
    if (c > COORD_HI) c = COORD_HI;
    if (c < COORD_LO) c = COORD_LO;
    return c[COORD_W-1:0];
  endfunction

  function automatic coord8_t rotate_quad(
    input coord8_t                    corner,
    input logic signed [COORD_W-1:0]  pvx,
    input logic signed [COORD_W-1:0]  pvy,
    input logic [qrp_pkg::ANGLE_W-1:0] ang
  );
    longint     cx, cy, dx, dy, x, y, sx, sy, z;
    logic [31:0] zu;
    logic        flip;
    coord8_t     res;
    cx = pvx;
    cy = pvy;
    zu = {ang, {(32 - qrp_pkg::ANGLE_W){1'b0}}};
    // second and third quadrants: negate and fold by a half turn
    flip = zu[31] ^ zu[30];
    if (flip) zu = zu + 32'h8000_0000;
    for (int k = 0; k < 4; k++) begin
      dx = $signed(corner[2*k]);
      dy = $signed(corner[2*k+1]);
      dx = dx - cx;
      dy = dy - cy;
      x = (dx * KINV + (64'sd1 <<< (29 - GUARD))) >>> (30 - GUARD);
      y = (dy * KINV + (64'sd1 <<< (29 - GUARD))) >>> (30 - GUARD);
      if (flip) begin
        x = -x;
        y = -y;
      end
      z = $signed(zu);
      for (int i = 0; i < STAGES; i++) begin
        sx = x >>> i;
        sy = y >>> i;
        if (z >= 0) begin
          x = x - sy;
          y = y + sx;
          z = z - ATAN_TURN[i];
        end else begin
          x = x + sy;
          y = y - sx;
          z = z + ATAN_TURN[i];
        end
      end
      res[2*k]   = clamp_coord(((x + (64'sd1 <<< (GUARD - 1))) >>> GUARD) + cx);
      res[2*k+1] = clamp_coord(((y + (64'sd1 <<< (GUARD - 1))) >>> GUARD) + cy);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_quads.push_back(rotate_quad(in_corners, in_mon.pivot_x, in_mon.pivot_y,
                                             in_mon.angle));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_quads.size() == 0) begin
          $error("result beat with no quad outstanding");
          mismatches++;
        end else begin
          want = expected_quads.pop_front();
          for (int j = 0; j < 8; j++) begin
            if (want[j] !== out_corners[j]) begin
              $error("%s: expected %0d, got %0d",
                     $sformatf("r%0d_%s", j / 2, (j % 2) ? "y" : "x"),
                     $signed(want[j]), $signed(out_corners[j]));
              mismatches++;
            end
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_quads.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int COORD_W    = qrp_pkg::COORD_W;
  localparam int ANGLE_W    = qrp_pkg::ANGLE_W;
  localparam int NUM_RANDOM = 1400;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 200;
  localparam int DRAIN_WAIT = 30;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] UNIT      = 24'sd256;
  localparam logic [COORD_W-1:0] NEG_UNIT  = -24'sd256;

  localparam logic [ANGLE_W-1:0] ANG_ZERO      = 16'h0000;
  localparam logic [ANGLE_W-1:0] ANG_EIGHTH    = 16'h2000;
  localparam logic [ANGLE_W-1:0] ANG_Q1_TOP    = 16'h3FFF;
  localparam logic [ANGLE_W-1:0] ANG_QUARTER   = 16'h4000;
  localparam logic [ANGLE_W-1:0] ANG_POS_MAX   = 16'h7FFF;
  localparam logic [ANGLE_W-1:0] ANG_HALF      = 16'h8000;
  localparam logic [ANGLE_W-1:0] ANG_Q2_BOTTOM = 16'hBFFF;
  localparam logic [ANGLE_W-1:0] ANG_NEG_QUART = 16'hC000;

  typedef logic [7:0][COORD_W-1:0] coord8_t;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   pending;
  int   sent_count;
  int   burst_left;
  int   idle_cycles;
  bit   hold_active;
  bit   held_off;

  qrp_in_if  in_bus ();
  qrp_out_if out_bus ();

  quad_rotate_about_pivot dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  quad_rotate_scoreboard u_scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_bus),
    .out_mon          (out_bus),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3:    return COORD_W'($urandom_range(0, 8191)) - COORD_W'(4096);
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(0, 19))
      0:       return ANG_HALF;
      1:       return ANG_QUARTER;
      2:       return ANG_NEG_QUART;
      3:       return ANG_Q1_TOP;
      4:       return ANG_Q2_BOTTOM;
      5:       return ANG_POS_MAX;
      6:       return ANG_ZERO;
      default: return ANGLE_W'($urandom());
    endcase
  endfunction

  task automatic drive_quad(
    input coord8_t             c,
    input logic [COORD_W-1:0]  pvx,
    input logic [COORD_W-1:0]  pvy,
    input logic [ANGLE_W-1:0]  ang
  );
    int gap;
    if (hold_active || burst_left > 0) begin
      gap = 0;
      if (burst_left > 0) burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) == 0) burst_left = 50;
    end
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.p0_x    <= c[0];
    in_bus.p0_y    <= c[1];
    in_bus.p1_x    <= c[2];
    in_bus.p1_y    <= c[3];
    in_bus.p2_x    <= c[4];
    in_bus.p2_y    <= c[5];
    in_bus.p3_x    <= c[6];
    in_bus.p3_y    <= c[7];
    in_bus.pivot_x <= pvx;
    in_bus.pivot_y <= pvy;
    in_bus.angle   <= ang;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sent_count++;
  endtask

  // stimulus and verdict
  initial begin
    coord8_t            sq, c;
    logic [COORD_W-1:0] pvx, pvy;
    rst_ni         <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.p0_x    <= '0;
    in_bus.p0_y    <= '0;
    in_bus.p1_x    <= '0;
    in_bus.p1_y    <= '0;
    in_bus.p2_x    <= '0;
    in_bus.p2_y    <= '0;
    in_bus.p3_x    <= '0;
    in_bus.p3_y    <= '0;
    in_bus.pivot_x <= '0;
    in_bus.pivot_y <= '0;
    in_bus.angle   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unit square on the axes about the origin
    sq = {NEG_UNIT, 24'd0, 24'd0, NEG_UNIT, UNIT, 24'd0, 24'd0, UNIT};
    drive_quad('0, '0, '0, ANG_ZERO);
    drive_quad({8{COORD_MAX}}, '0, '0, ANG_ZERO);
    drive_quad({8{COORD_MIN}}, '0, '0, ANG_ZERO);
    drive_quad({8{COORD_MAX}}, COORD_MIN, COORD_MIN, ANG_ZERO);
    // half turn with the largest offsets: saturates both ways
    drive_quad({8{COORD_MAX}}, COORD_MIN, COORD_MIN, ANG_HALF);
    drive_quad({8{COORD_MIN}}, COORD_MAX, COORD_MAX, ANG_HALF);
    drive_quad(sq, '0, '0, ANG_QUARTER);
    drive_quad(sq, '0, '0, ANG_NEG_QUART);
    drive_quad(sq, '0, '0, ANG_EIGHTH);
    drive_quad(sq, '0, '0, ANG_POS_MAX);
    drive_quad(sq, '0, '0, ANG_Q1_TOP);
    drive_quad(sq, '0, '0, ANG_Q2_BOTTOM);
    drive_quad(sq, '0, '0, ANG_HALF);
    drive_quad(sq, 24'sd1000, -24'sd2000, 16'sd12345);
    // corners sitting on the pivot
    drive_quad({4{-24'sd1000, 24'sd1000}}, 24'sd1000, -24'sd1000, 16'sd12345);
    drive_quad({4{COORD_MIN, COORD_MAX}}, '0, '0, ANG_EIGHTH);
    drive_quad({8{COORD_MIN}}, COORD_MAX, COORD_MAX, ANG_EIGHTH);
    drive_quad({8{COORD_MAX}}, COORD_MAX, COORD_MIN, ANG_POS_MAX);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      pvx = rand_coord();
      pvy = rand_coord();
      for (int j = 0; j < 8; j++) begin
        if ($urandom_range(0, 1) == 0) begin
          c[j] = ((j % 2) ? pvy : pvx) + COORD_W'($urandom_range(0, 8191)) - 24'd4096;
        end else begin
          c[j] = rand_coord();
        end
      end
      drive_quad(c, pvx, pvy, rand_angle());
    end
    in_bus.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold-off to back the pipe up
  initial begin
    int hi_len, lo_len;
    out_bus.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && sent_count >= HOLD_AT) begin
        hold_active = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        held_off    = 1'b1;
        hold_active = 1'b0;
      end
      hi_len = ($urandom_range(0, 19) == 0) ? 100 : $urandom_range(1, 12);
      lo_len = pick_gap();
      out_bus.ready <= 1'b1;
      repeat (hi_len) @(posedge clk_i);
      if (lo_len > 0) begin
        out_bus.ready <= 1'b0;
        repeat (lo_len) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
